/* hdl/blc_pkg.sv */
// Shared types and constants for the battery level classifier.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package blc_pkg;

    localparam int SAMPLES_PER_SET = 8;
    localparam int IDX_W           = $clog2(SAMPLES_PER_SET);

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_DEPLETED_BELOW    = 3'd0;
    localparam logic [2:0] REG_LOW_BELOW         = 3'd1;
    localparam logic [2:0] REG_LOW_RECOVER_ABOVE = 3'd2;
    localparam logic [2:0] REG_FULL_BAND_BELOW   = 3'd3;
    localparam logic [2:0] REG_FULL_EXIT_BELOW   = 3'd4;
    localparam logic [2:0] REG_FULL_ENTER_ABOVE  = 3'd5;
    localparam logic [2:0] REG_PERSIST_COUNT     = 3'd6;

    // Reset values of the registers
    localparam logic [11:0] RST_DEPLETED_BELOW    = 12'd2348;
    localparam logic [11:0] RST_LOW_BELOW         = 12'd2607;
    localparam logic [11:0] RST_LOW_RECOVER_ABOVE = 12'd2400;
    localparam logic [11:0] RST_FULL_BAND_BELOW   = 12'd3080;
    localparam logic [11:0] RST_FULL_EXIT_BELOW   = 12'd3070;
    localparam logic [11:0] RST_FULL_ENTER_ABOVE  = 12'd3085;
    localparam logic [7:0]  RST_PERSIST_COUNT     = 8'd50;

    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_LOW      = 2'd1,
        ST_FULL     = 2'd2,
        ST_DEPLETED = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] sample_high;
        logic [3:0] sample_low;
        logic       flash_active;
    } in_t;

    typedef struct packed {
        logic [1:0]  battery_status;
        logic [11:0] average_value;
        logic        clear_low_latch;
    } out_t;

    typedef struct packed {
        logic [11:0] depleted_below;
        logic [11:0] low_below;
        logic [11:0] low_recover_above;
        logic [11:0] full_band_below;
        logic [11:0] full_exit_below;
        logic [11:0] full_enter_above;
        logic [7:0]  persist_count;
    } cfg_t;

    // One finished set, passed from the accumulator to the classifier
    typedef struct packed {
        logic [11:0] avg;
        logic        flash;
    } set_t;

endpackage

/* hdl/blc_regs.sv */
// APB-style configuration registers of the battery level classifier.
// Depends on blc_pkg for the register indexes, reset values and cfg_t.
module blc_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [blc_pkg::PADDR_W-1:0] paddr,
    input  logic [blc_pkg::PDATA_W-1:0] pwdata,
    output logic [blc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output blc_pkg::cfg_t               cfg
);

    blc_pkg::cfg_t cfg_reg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depleted_below    <= blc_pkg::RST_DEPLETED_BELOW;
            cfg_reg.low_below         <= blc_pkg::RST_LOW_BELOW;
            cfg_reg.low_recover_above <= blc_pkg::RST_LOW_RECOVER_ABOVE;
            cfg_reg.full_band_below   <= blc_pkg::RST_FULL_BAND_BELOW;
            cfg_reg.full_exit_below   <= blc_pkg::RST_FULL_EXIT_BELOW;
            cfg_reg.full_enter_above  <= blc_pkg::RST_FULL_ENTER_ABOVE;
            cfg_reg.persist_count     <= blc_pkg::RST_PERSIST_COUNT;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                blc_pkg::REG_DEPLETED_BELOW:    cfg_reg.depleted_below    <= pwdata[11:0];
                blc_pkg::REG_LOW_BELOW:         cfg_reg.low_below         <= pwdata[11:0];
                blc_pkg::REG_LOW_RECOVER_ABOVE: cfg_reg.low_recover_above <= pwdata[11:0];
                blc_pkg::REG_FULL_BAND_BELOW:   cfg_reg.full_band_below   <= pwdata[11:0];
                blc_pkg::REG_FULL_EXIT_BELOW:   cfg_reg.full_exit_below   <= pwdata[11:0];
                blc_pkg::REG_FULL_ENTER_ABOVE:  cfg_reg.full_enter_above  <= pwdata[11:0];
                blc_pkg::REG_PERSIST_COUNT:     cfg_reg.persist_count     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            blc_pkg::REG_DEPLETED_BELOW:    prdata = {20'd0, cfg_reg.depleted_below};
            blc_pkg::REG_LOW_BELOW:         prdata = {20'd0, cfg_reg.low_below};
            blc_pkg::REG_LOW_RECOVER_ABOVE: prdata = {20'd0, cfg_reg.low_recover_above};
            blc_pkg::REG_FULL_BAND_BELOW:   prdata = {20'd0, cfg_reg.full_band_below};
            blc_pkg::REG_FULL_EXIT_BELOW:   prdata = {20'd0, cfg_reg.full_exit_below};
            blc_pkg::REG_FULL_ENTER_ABOVE:  prdata = {20'd0, cfg_reg.full_enter_above};
            blc_pkg::REG_PERSIST_COUNT:     prdata = {24'd0, cfg_reg.persist_count};
            default:                        prdata = '0;
        endcase
    end

endmodule

/* hdl/blc_accum.sv */
// Sample accumulator: sums high bytes and low nibbles of each set and forms the average.
// Depends on blc_pkg for in_t, set_t and the set size.
module blc_accum (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  blc_pkg::in_t   in_data,
    output logic           set_valid,
    input  logic           set_ready,
    output blc_pkg::set_t  set_data
);

    logic [10:0]             high_sum_reg, high_sum_next;
    logic [6:0]              low_sum_reg, low_sum_next;
    logic [blc_pkg::IDX_W-1:0] index_reg, index_next;
    logic                    set_valid_reg, set_valid_next;
    blc_pkg::set_t           set_data_reg, set_data_next;

    logic        take;
    logic        last;
    logic [10:0] high_add;
    logic [6:0]  low_add;
    logic [14:0] total;

    assign in_ready  = !set_valid_reg || set_ready;
    assign take      = in_valid && in_ready;
    assign last      = (index_reg == blc_pkg::IDX_W'(blc_pkg::SAMPLES_PER_SET - 1));
    assign set_valid = set_valid_reg;
    assign set_data  = set_data_reg;

    assign high_add = high_sum_reg + {3'd0, in_data.sample_high};
    assign low_add  = low_sum_reg + {3'd0, in_data.sample_low};
    // Keep only the upper nibble of the low sum, then divide the total by eight
    assign total    = {high_add, 4'd0} + {8'd0, low_add[6:4], 4'd0};

    always_comb
    begin
        high_sum_next  = high_sum_reg;
        low_sum_next   = low_sum_reg;
        index_next     = index_reg;
        set_valid_next = set_valid_reg && !set_ready;
        set_data_next  = set_data_reg;
        if (take)
        begin
            if (last)
            begin
                high_sum_next      = '0;
                low_sum_next       = '0;
                index_next         = '0;
                set_valid_next     = 1'b1;
                set_data_next.avg  = total[14:3];
                set_data_next.flash = in_data.flash_active;
            end
            else
            begin
                high_sum_next = high_add;
                low_sum_next  = low_add;
                index_next    = index_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_sum_reg  <= '0;
            low_sum_reg   <= '0;
            index_reg     <= '0;
            set_valid_reg <= 1'b0;
        end
        else
        begin
            high_sum_reg  <= high_sum_next;
            low_sum_reg   <= low_sum_next;
            index_reg     <= index_next;
            set_valid_reg <= set_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_data_reg <= set_data_next;
    end

endmodule

/* hdl/blc_classify.sv */
// Battery status state machine with persistence counter and result register.
// Depends on blc_pkg for status_t, set_t, cfg_t and out_t.
module blc_classify (
    input  logic           clk,
    input  logic           rst_n,
    input  blc_pkg::cfg_t  cfg,
    input  logic           set_valid,
    output logic           set_ready,
    input  blc_pkg::set_t  set_data,
    output logic           out_valid,
    input  logic           out_ready,
    output blc_pkg::out_t  out_data
);

    blc_pkg::status_t status_reg, status_next;
    logic [7:0]       cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    blc_pkg::out_t    out_data_reg, out_data_next;

    logic       take;
    logic       in_depleted, in_low, in_normal;
    logic [7:0] cnt_bump;
    logic       bump_over;
    logic       clr;

    assign set_ready = !out_valid_reg || out_ready;
    assign take      = set_valid && set_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Bands are tested in fixed order, whatever the thresholds hold
    assign in_depleted = set_data.avg < cfg.depleted_below;
    assign in_low      = !in_depleted && (set_data.avg < cfg.low_below);
    assign in_normal   = !in_depleted && !in_low && (set_data.avg < cfg.full_band_below);

    assign cnt_bump  = (cnt_reg == blc_pkg::COUNT_MAX) ? cnt_reg : cnt_reg + 8'd1;
    assign bump_over = cnt_bump > cfg.persist_count;

    // Next state
    always_comb
    begin
        status_next = status_reg;
        if (in_depleted)
        begin
            if (bump_over)
                status_next = blc_pkg::ST_DEPLETED;
        end
        else if (in_low)
        begin
            if (!set_data.flash)
                status_next = blc_pkg::ST_LOW;
        end
        else if (in_normal)
        begin
            case (status_reg)
                blc_pkg::ST_FULL:
                begin
                    if (set_data.avg < cfg.full_exit_below)
                        status_next = blc_pkg::ST_NORMAL;
                end
                blc_pkg::ST_LOW, blc_pkg::ST_DEPLETED:
                begin
                    if (bump_over)
                        status_next = blc_pkg::ST_NORMAL;
                end
                default: ;
            endcase
        end
        else
        begin
            if (set_data.avg > cfg.full_enter_above)
                status_next = blc_pkg::ST_FULL;
        end
    end

    // Counter and latch-clear flag
    always_comb
    begin
        cnt_next = cnt_reg;
        clr      = 1'b0;
        if (in_depleted)
        begin
            cnt_next = cnt_bump;
        end
        else if (in_low)
        begin
            cnt_next = '0;
            clr      = set_data.avg > cfg.low_recover_above;
        end
        else if (in_normal)
        begin
            case (status_reg)
                blc_pkg::ST_FULL:
                    clr = set_data.avg < cfg.full_exit_below;
                blc_pkg::ST_LOW, blc_pkg::ST_DEPLETED:
                begin
                    cnt_next = cnt_bump;
                    clr      = bump_over;
                end
                default: ;
            endcase
        end
        else
        begin
            cnt_next = '0;
            clr      = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (take)
        begin
            out_valid_next                = 1'b1;
            out_data_next.battery_status  = status_next;
            out_data_next.average_value   = set_data.avg;
            out_data_next.clear_low_latch = clr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg    <= blc_pkg::ST_NORMAL;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                status_reg <= status_next;
                cnt_reg    <= cnt_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

/* hdl/battery_level_classifier.sv */
// Top level of the battery level classifier.
// Depends on blc_pkg, blc_regs, blc_accum and blc_classify.
//
// Input channel (in_valid/in_ready/in_data): one beat per raw 12-bit ADC
// conversion, split into sample_high, sample_low and flash_active.
// Every eighth accepted beat closes a set; its average and the updated
// battery status leave on the output channel (out_valid/out_ready/out_data)
// as one beat. Other input beats produce no output.
// Throughput: one input beat per cycle while in_ready is high, set by the single accumulator stage.
// The result of a set is registered in the accumulator stage, then in the
// classifier result register, before it leaves on the output channel.
// A stall on out_ready fills the result register and then the set register;
// in_ready drops only when both are full, so input beats keep flowing while
// a finished result waits.
// Configuration: APB-style port, register i at byte address 4*i, pready
// always high; write only while no set is in flight.
// Reset (rst_n low, asynchronous) discards any partial set, returns status to
// normal, clears the persistence counter and reloads the thresholds.
module battery_level_classifier (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  blc_pkg::in_t                in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output blc_pkg::out_t               out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [blc_pkg::PADDR_W-1:0] paddr,
    input  logic [blc_pkg::PDATA_W-1:0] pwdata,
    output logic [blc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    blc_pkg::cfg_t cfg;
    logic          set_valid;
    logic          set_ready;
    blc_pkg::set_t set_data;

    blc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    blc_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .set_valid (set_valid),
        .set_ready (set_ready),
        .set_data  (set_data)
    );

    blc_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .set_valid (set_valid),
        .set_ready (set_ready),
        .set_data  (set_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // A new result only follows a set beat taken by the classifier
    a_out_from_set: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(set_valid && set_ready))
        else $error("result appeared without a finished set");

    // Input backpressure only when a finished set and a result are both waiting
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> set_valid && out_valid)
        else $error("input stalled with room in the pipeline");

    // A set stalled by the classifier is held
    a_set_hold: assert property (@(posedge clk) disable iff (!rst_n)
        set_valid && !set_ready |=> set_valid && $stable(set_data))
        else $error("stalled set beat was lost or changed");

endmodule

/* tb/tb_battery_level_classifier.sv */
// Self-checking bench for battery_level_classifier: random ADC conversion beats against
// an in-bench classifier, with threshold settings changed over APB between phases.
// Depends on blc_pkg and hdl/battery_level_classifier.sv.
module tb_battery_level_classifier;

    localparam int LIMIT_CYCLES = 800000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic          in_valid = 1'b0;
    logic          in_ready;
    blc_pkg::in_t  in_data = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    blc_pkg::out_t out_data;

    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [blc_pkg::PADDR_W-1:0] paddr = '0;
    logic [blc_pkg::PDATA_W-1:0] pwdata = '0;
    logic [blc_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    battery_level_classifier uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Classifier mirror: thresholds, accumulator and status
    blc_pkg::cfg_t limits = '{
        depleted_below:    blc_pkg::RST_DEPLETED_BELOW,
        low_below:         blc_pkg::RST_LOW_BELOW,
        low_recover_above: blc_pkg::RST_LOW_RECOVER_ABOVE,
        full_band_below:   blc_pkg::RST_FULL_BAND_BELOW,
        full_exit_below:   blc_pkg::RST_FULL_EXIT_BELOW,
        full_enter_above:  blc_pkg::RST_FULL_ENTER_ABOVE,
        persist_count:     blc_pkg::RST_PERSIST_COUNT
    };
    logic [10:0]      acc_high = '0;
    logic [6:0]       acc_low = '0;
    logic [2:0]       acc_pos = '0;
    blc_pkg::status_t cur_status = blc_pkg::ST_NORMAL;
    logic [7:0]       persist_cnt = '0;

    blc_pkg::in_t  conversion_q[$];
    blc_pkg::out_t status_due[$];

    bit feed_idle = 1'b0;
    bit drain_idle = 1'b0;
    bit conv_taken = 1'b0;
    int feed_gap = 0;
    int stall_left = 0;
    int pushed_cnt = 0;
    int taken_cnt = 0;
    int sets_checked = 0;
    int settings_cnt = 0;
    int mismatch_cnt = 0;
    int cycle_cnt = 0;
    int seen[4] = '{0, 0, 0, 0};

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic logic [11:0] clamp12(input int v);
        if (v < 0)
            return 12'd0;
        if (v > 4095)
            return 12'd4095;
        return 12'(v);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return $urandom_range(2, 1);
        else if (r < 88)
            return $urandom_range(6, 3);
        else if (r < 97)
            return $urandom_range(15, 7);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [7:0] bumped(input logic [7:0] c);
        return (c == blc_pkg::COUNT_MAX) ? c : c + 8'd1;
    endfunction

    // Accumulate one conversion; on the eighth, classify the set and queue its result
    task automatic classify_sample(input blc_pkg::in_t s);
        logic [15:0]   total;
        logic [11:0]   avg;
        logic          clr;
        blc_pkg::out_t res;
        acc_high = acc_high + 11'(s.sample_high);
        acc_low  = acc_low + 7'(s.sample_low);
        if (acc_pos < 3'(blc_pkg::SAMPLES_PER_SET - 1)) begin
            acc_pos = acc_pos + 3'd1;
            return;
        end
        // keep only the upper nibble of the low sum, then divide by 8
        total = {1'b0, acc_high, 4'h0} + {9'd0, acc_low & 7'h70};
        avg = total[14:3];
        acc_high = '0;
        acc_low = '0;
        acc_pos = '0;
        clr = 1'b0;
        if (avg < limits.depleted_below) begin
            persist_cnt = bumped(persist_cnt);
            if (persist_cnt > limits.persist_count)
                cur_status = blc_pkg::ST_DEPLETED;
        end else if (avg < limits.low_below) begin
            persist_cnt = '0;
            if (!s.flash_active)
                cur_status = blc_pkg::ST_LOW;
            if (avg > limits.low_recover_above)
                clr = 1'b1;
        end else if (avg < limits.full_band_below) begin
            if (cur_status == blc_pkg::ST_FULL) begin
                if (avg < limits.full_exit_below) begin
                    cur_status = blc_pkg::ST_NORMAL;
                    clr = 1'b1;
                end
            end else if (cur_status != blc_pkg::ST_NORMAL) begin
                persist_cnt = bumped(persist_cnt);
                if (persist_cnt > limits.persist_count) begin
                    cur_status = blc_pkg::ST_NORMAL;
                    clr = 1'b1;
                end
            end
        end else begin
            persist_cnt = '0;
            clr = 1'b1;
            if (avg > limits.full_enter_above)
                cur_status = blc_pkg::ST_FULL;
        end
        res.battery_status = cur_status;
        res.average_value = avg;
        res.clear_low_latch = clr;
        status_due.push_back(res);
    endtask

    // Input driver: hold each beat until taken, then idle for the chosen gap
    always @(negedge clk) begin
        if (rst_n && (!in_valid || conv_taken)) begin
            if (feed_gap > 0) begin
                feed_gap--;
                in_valid <= 1'b0;
            end else if (conversion_q.size() > 0) begin
                in_data <= conversion_q.pop_front();
                in_valid <= 1'b1;
                if (feed_idle && $urandom_range(99) < 35)
                    feed_gap = pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output side back-pressure
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if (drain_idle && $urandom_range(99) < 20)
                stall_left = pick_gap();
        end
    end

    // Monitor: check result beats, feed accepted conversions and register writes to the mirror
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (status_due.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: result beat with none expected: status %0d avg %0d clear %0b",
                                 $time, out_data.battery_status, out_data.average_value,
                                 out_data.clear_low_latch);
                end else begin
                    if (out_data.battery_status !== status_due[0].battery_status ||
                        out_data.average_value !== status_due[0].average_value ||
                        out_data.clear_low_latch !== status_due[0].clear_low_latch) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("%0t: mismatch: expected status %0d avg %0d clear %0b",
                                     $time, status_due[0].battery_status,
                                     status_due[0].average_value, status_due[0].clear_low_latch);
                            $display("    got status %0d avg %0d clear %0b",
                                     out_data.battery_status, out_data.average_value,
                                     out_data.clear_low_latch);
                        end
                    end
                    void'(status_due.pop_front());
                    sets_checked++;
                    seen[out_data.battery_status]++;
                end
            end
            conv_taken = in_valid && in_ready;
            if (conv_taken) begin
                classify_sample(in_data);
                taken_cnt++;
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    blc_pkg::REG_DEPLETED_BELOW:    limits.depleted_below = pwdata[11:0];
                    blc_pkg::REG_LOW_BELOW:         limits.low_below = pwdata[11:0];
                    blc_pkg::REG_LOW_RECOVER_ABOVE: limits.low_recover_above = pwdata[11:0];
                    blc_pkg::REG_FULL_BAND_BELOW:   limits.full_band_below = pwdata[11:0];
                    blc_pkg::REG_FULL_EXIT_BELOW:   limits.full_exit_below = pwdata[11:0];
                    blc_pkg::REG_FULL_ENTER_ABOVE:  limits.full_enter_above = pwdata[11:0];
                    blc_pkg::REG_PERSIST_COUNT:     limits.persist_count = pwdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("battery_level_classifier verification failed");
            $finish;
        end
    end

    // Junk above the field width must be dropped by the block
    task automatic write_limit(input logic [2:0] idx, input logic [11:0] value, input int width);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= (32'($urandom()) << width) | 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apply_limits(input blc_pkg::cfg_t plan);
        write_limit(blc_pkg::REG_DEPLETED_BELOW, plan.depleted_below, 12);
        write_limit(blc_pkg::REG_LOW_BELOW, plan.low_below, 12);
        write_limit(blc_pkg::REG_LOW_RECOVER_ABOVE, plan.low_recover_above, 12);
        write_limit(blc_pkg::REG_FULL_BAND_BELOW, plan.full_band_below, 12);
        write_limit(blc_pkg::REG_FULL_EXIT_BELOW, plan.full_exit_below, 12);
        write_limit(blc_pkg::REG_FULL_ENTER_ABOVE, plan.full_enter_above, 12);
        write_limit(blc_pkg::REG_PERSIST_COUNT, {4'($urandom()), plan.persist_count}, 8);
        settings_cnt++;
    endtask

    // Queue one set of eight conversions around a target average
    task automatic queue_set(input logic [11:0] target, input int jitter, input bit noisy,
                             input int flash_pct);
        blc_pkg::in_t s;
        logic [11:0]  v;
        for (int k = 0; k < blc_pkg::SAMPLES_PER_SET; k++) begin
            v = clamp12(int'(target) + int'($urandom_range(2 * jitter)) - jitter);
            s.sample_high = noisy ? 8'($urandom()) : v[11:4];
            s.sample_low = noisy ? 4'($urandom()) : v[3:0];
            s.flash_active = ($urandom_range(99) < flash_pct);
            conversion_q.push_back(s);
            pushed_cnt++;
        end
    endtask

    // Wait until every beat is taken and every result is back, plus the pipeline depth
    task automatic drain();
        while (taken_cnt != pushed_cnt || status_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic logic [11:0] pick_target();
        int mark;
        case ($urandom_range(9))
            0: return 12'($urandom());
            1: return ($urandom_range(1) != 0) ? 12'hFFF : 12'h000;
            default: begin
                case ($urandom_range(5))
                    0: mark = limits.depleted_below;
                    1: mark = limits.low_below;
                    2: mark = limits.low_recover_above;
                    3: mark = limits.full_band_below;
                    4: mark = limits.full_exit_below;
                    default: mark = limits.full_enter_above;
                endcase
                return clamp12(mark + int'($urandom_range(8)) - 4);
            end
        endcase
    endfunction

    // Runs of sets near one level, of random length up to the persistence count plus three, capped at 60 sets
    task automatic run_phase(input int nsets, input bit gaps_in, input bit gaps_out);
        int          done_sets;
        int          run_len;
        int          cap;
        int          jitter;
        int          flash_pct;
        bit          noisy;
        logic [11:0] target;
        feed_idle = gaps_in;
        drain_idle = gaps_out;
        cap = int'(limits.persist_count) + 3;
        if (cap > 60)
            cap = 60;
        done_sets = 0;
        while (done_sets < nsets) begin
            target = pick_target();
            run_len = $urandom_range(cap, 1);
            noisy = ($urandom_range(9) == 0);
            jitter = $urandom_range(3) * 3;
            flash_pct = ($urandom_range(1) != 0) ? 0 : $urandom_range(100);
            for (int k = 0; k < run_len && done_sets < nsets; k++) begin
                queue_set(target, jitter, noisy, flash_pct);
                done_sets++;
            end
        end
        drain();
    endtask

    initial begin
        blc_pkg::cfg_t plan;
        int            base;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset thresholds: all-ones set, all-zeros set, low band with flashing on
        feed_idle = 1'b1;
        drain_idle = 1'b1;
        queue_set(12'hFFF, 0, 1'b0, 0);
        queue_set(12'h000, 0, 1'b0, 100);
        queue_set(12'd2500, 0, 1'b0, 100);
        drain();

        plan = limits;
        plan.persist_count = 8'd2;
        apply_limits(plan);
        run_phase(14, 1'b1, 1'b1);

        plan = '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'd0};
        apply_limits(plan);
        run_phase(8, 1'b0, 1'b0);

        plan = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 8'hFF};
        apply_limits(plan);
        run_phase(8, 1'b1, 1'b1);

        // Thresholds in any order, bands possibly empty
        plan = '{12'($urandom()), 12'($urandom()), 12'($urandom()), 12'($urandom()),
                 12'($urandom()), 12'($urandom()), 8'($urandom_range(6))};
        apply_limits(plan);
        run_phase(14, 1'b1, 1'b0);

        base = $urandom_range(3500, 1500);
        plan.depleted_below = clamp12(base - 300);
        plan.low_recover_above = clamp12(base - 200);
        plan.low_below = clamp12(base);
        plan.full_exit_below = clamp12(base + 400);
        plan.full_band_below = clamp12(base + 410);
        plan.full_enter_above = clamp12(base + 420);
        plan.persist_count = 8'($urandom_range(5, 1));
        apply_limits(plan);
        run_phase(14, 1'b0, 1'b1);

        plan = '{blc_pkg::RST_DEPLETED_BELOW, blc_pkg::RST_LOW_BELOW,
                 blc_pkg::RST_LOW_RECOVER_ABOVE, blc_pkg::RST_FULL_BAND_BELOW,
                 blc_pkg::RST_FULL_EXIT_BELOW, blc_pkg::RST_FULL_ENTER_ABOVE,
                 blc_pkg::RST_PERSIST_COUNT};
        apply_limits(plan);
        run_phase(14, 1'b1, 1'b1);

        // Hold in depleted well past the count, then recover to normal
        plan.persist_count = 8'd6;
        apply_limits(plan);
        feed_idle = 1'b0;
        drain_idle = 1'b0;
        queue_set(12'd4000, 0, 1'b0, 0);
        for (int k = 0; k < 10; k++)
            queue_set(12'd1000, 200, 1'b0, 50);
        queue_set(12'd2800, 0, 1'b0, 0);
        drain();

        repeat (10) @(posedge clk);
        if (status_due.size() != 0)
            mismatch_cnt++;
        $display("Ran %0d conversions into %0d checked sets under %0d register settings",
                 taken_cnt, sets_checked, settings_cnt + 1);
        $display("Status seen: normal %0d, low %0d, full %0d, depleted %0d; mismatches %0d",
                 seen[0], seen[1], seen[2], seen[3], mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("battery_level_classifier verification clean");
        else
            $display("battery_level_classifier verification failed");
        $finish;
    end

endmodule

/* files.f */
hdl/blc_pkg.sv
hdl/blc_regs.sv
hdl/blc_accum.sv
hdl/blc_classify.sv
hdl/battery_level_classifier.sv
tb/tb_battery_level_classifier.sv
